[rtl/assert_macros.svh]
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property check on the rising clock, off while reset is high.
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must hold at every clock outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   `ASSERT_PROP(lbl, clk, rst, (cond), msg)

`endif

[rtl/fir_lp_pkg.sv]
// Constants, types and coefficient table of the 42-tap low-pass FIR.
package fir_lp_pkg;

   localparam int TAPS           = 42;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 16;
   localparam int COEF_FRAC_BITS = 15;
   localparam int ROM_LEN        = 42;

   localparam int TAP_BITS  = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int FILL_BITS = $clog2(TAPS + 1);
   localparam int PROD_BITS = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_BITS  = PROD_BITS + TAP_BITS;

   localparam logic signed [COEF_BITS-1:0] COEF_TABLE [ROM_LEN] = '{
      -16'sd223, -16'sd144, -16'sd174, -16'sd190, -16'sd190, -16'sd164,
      -16'sd105, -16'sd10,   16'sd121,  16'sd298,  16'sd511,  16'sd757,
       16'sd1032, 16'sd1324, 16'sd1622, 16'sd1914, 16'sd2182, 16'sd2415,
       16'sd2605, 16'sd2733, 16'sd2802, 16'sd2802, 16'sd2733, 16'sd2605,
       16'sd2415, 16'sd2182, 16'sd1914, 16'sd1622, 16'sd1324, 16'sd1032,
       16'sd757,  16'sd511,  16'sd298,  16'sd121, -16'sd10,  -16'sd105,
      -16'sd164, -16'sd190, -16'sd190, -16'sd174, -16'sd144, -16'sd223
   };

   typedef struct packed {
      logic                valid;
      logic                first;
      logic                last;
      logic [TAP_BITS-1:0] tap;
   } mac_issue_type;

   function automatic logic signed [COEF_BITS-1:0] coef_at(input logic [TAP_BITS-1:0] idx);
      logic signed [COEF_BITS-1:0] c;
      c = '0;
      if (int'(idx) < ROM_LEN) begin
         c = COEF_TABLE[idx];
      end
      return c;
   endfunction

endpackage

[rtl/fir_lp_delay_ram.sv]
// Circular delay-line memory, one write and one registered read port.
module fir_lp_delay_ram
   import fir_lp_pkg::*;
(
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [TAP_BITS-1:0]           wr_addr,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [TAP_BITS-1:0]           rd_addr,
   output logic signed [SAMPLE_BITS-1:0] rd_data
);

   logic signed [SAMPLE_BITS-1:0] mem [TAPS];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/fir_lp_mac.sv]
// Pipelined multiply-accumulate with truncation and saturation.
module fir_lp_mac
   import fir_lp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  mac_issue_type                 issue,
   input  logic signed [SAMPLE_BITS-1:0] rd_data,
   output logic                          done,
   output logic signed [SAMPLE_BITS-1:0] result
);

   localparam logic signed [ACC_BITS-1:0] ROUND_BIAS =
      ACC_BITS'((64'd1 << COEF_FRAC_BITS) - 64'd1);
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      ACC_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic signed [ACC_BITS-1:0] SAT_LO = -SAT_HI - ACC_BITS'(1);

   logic                          v1_ff, first1_ff, last1_ff;
   logic signed [COEF_BITS-1:0]   coef1_ff;
   logic                          v2_ff, first2_ff, last2_ff;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic                          fin_ff;
   logic                          done_ff;
   logic signed [SAMPLE_BITS-1:0] result_ff;

   logic signed [ACC_BITS-1:0]    biased;
   logic signed [ACC_BITS-1:0]    quot;
   logic signed [SAMPLE_BITS-1:0] result_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         v1_ff   <= issue.valid;
         v2_ff   <= v1_ff;
         fin_ff  <= v2_ff && last2_ff;
         done_ff <= fin_ff;
      end
   end

   always_ff @(posedge clock) begin
      first1_ff <= issue.first;
      last1_ff  <= issue.last;
      coef1_ff  <= coef_at(issue.tap);
      first2_ff <= first1_ff;
      last2_ff  <= last1_ff;
      prod_ff   <= rd_data * coef1_ff;
      if (v2_ff) begin
         acc_ff <= first2_ff ? ACC_BITS'(prod_ff) : acc_ff + ACC_BITS'(prod_ff);
      end
      if (fin_ff) begin
         result_ff <= result_in;
      end
   end

   // truncate toward zero, then clamp
   always_comb begin
      biased = acc_ff + (acc_ff[ACC_BITS-1] ? ROUND_BIAS : '0);
      quot   = biased >>> COEF_FRAC_BITS;
      if (quot > SAT_HI) begin
         result_in = SAT_HI[SAMPLE_BITS-1:0];
      end else if (quot < SAT_LO) begin
         result_in = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         result_in = quot[SAMPLE_BITS-1:0];
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

[rtl/fir_lowpass_42tap_top.sv]
// Top level of the 42-tap low-pass FIR: request control, fill tracking, output register.
// A filtered request writes its sample into the delay RAM at the accepting edge, then
// reads the 42 taps of that single-read-port RAM in turn into one shared multiplier and
// accumulator, passes through the multiply, accumulate, clamp and hand-off pipeline, and
// is then loaded into the output register. The request port stays stalled until that
// load, so a new request is not accepted before the last filtered one is through. A
// stalled output holds the finished value and keeps the request port stalled. Restart
// requests clear the fill count and give no response; requests during the fill (the
// discarded first sample and the 41 that follow) return the last filtered value. The
// delay RAM needs no clearing after reset since the fill and the first filtered request
// rewrite every tap before the first filtered result.
`include "assert_macros.svh"

module fir_lowpass_42tap_top
   import fir_lp_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_kind,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_filtered
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_MAC   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [FILL_BITS-1:0]          fill_ff, fill_in;
   logic [TAP_BITS-1:0]           wp_ff, wp_in;
   logic [TAP_BITS-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [TAP_BITS-1:0]           tap_ff, tap_in;
   logic signed [SAMPLE_BITS-1:0] held_ff, held_in;
   logic signed [SAMPLE_BITS-1:0] res_ff, res_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_filtered_ff, rsp_filtered_in;

   logic                          accept;
   logic                          slot_free;
   logic                          wr_en;
   logic                          line_full;
   logic                          filter_start;
   mac_issue_type                 issue;
   logic signed [SAMPLE_BITS-1:0] rd_data;
   logic                          mac_done;
   logic signed [SAMPLE_BITS-1:0] mac_result;

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign slot_free    = !rsp_valid_ff || !rsp_stall;
   assign line_full    = (fill_ff == FILL_BITS'(TAPS));
   assign wr_en        = accept && !req_kind && (fill_ff != '0);
   assign filter_start = accept && !req_kind && line_full;

   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      wp_in           = wp_ff;
      rd_ptr_in       = rd_ptr_ff;
      tap_in          = tap_ff;
      held_in         = held_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_filtered_in = rsp_filtered_ff;
      issue.valid     = 1'b0;
      issue.first     = (tap_ff == '0);
      issue.last      = (tap_ff == TAP_BITS'(TAPS - 1));
      issue.tap       = tap_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_kind) begin
                  fill_in = '0;
               end else if (line_full) begin
                  wp_in     = (wp_ff == TAP_BITS'(TAPS - 1)) ? '0 : wp_ff + TAP_BITS'(1);
                  rd_ptr_in = wp_ff;
                  tap_in    = '0;
                  state_in  = ST_MAC;
               end else begin
                  if (fill_ff != '0) begin
                     wp_in = (wp_ff == TAP_BITS'(TAPS - 1)) ? '0 : wp_ff + TAP_BITS'(1);
                  end
                  fill_in = fill_ff + FILL_BITS'(1);
                  if (slot_free) begin
                     rsp_valid_in    = 1'b1;
                     rsp_filtered_in = held_ff;
                  end else begin
                     res_in   = held_ff;
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_MAC: begin
            issue.valid = 1'b1;
            rd_ptr_in   = (rd_ptr_ff == '0) ? TAP_BITS'(TAPS - 1) : rd_ptr_ff - TAP_BITS'(1);
            tap_in      = tap_ff + TAP_BITS'(1);
            if (issue.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (mac_done) begin
               held_in  = mac_result;
               res_in   = mac_result;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in    = 1'b1;
               rsp_filtered_in = res_ff;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         wp_ff        <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         wp_ff        <= wp_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff       <= rd_ptr_in;
      tap_ff          <= tap_in;
      res_ff          <= res_in;
      rsp_filtered_ff <= rsp_filtered_in;
   end

   fir_lp_delay_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (req_sample),
      .rd_en   (issue.valid),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   fir_lp_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .issue   (issue),
      .rd_data (rd_data),
      .done    (mac_done),
      .result  (mac_result)
   );

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   `ASSERT_ALWAYS(a_done_in_drain, clock, reset, !mac_done || state_ff == ST_DRAIN, "mac done outside drain")
   `ASSERT_ALWAYS(a_fill_bound, clock, reset, fill_ff <= FILL_BITS'(TAPS), "fill count past tap count")
   `ASSERT_ALWAYS(a_wp_bound, clock, reset, wp_ff < TAP_BITS'(TAPS), "write pointer out of range")
   `ASSERT_PROP(a_mac_start, clock, reset, filter_start |=> state_ff == ST_MAC, "mac did not start")

endmodule
